[rtl/core/emt_pkg.sv]
// Shared widths, codes and request/status types of the multiturn encoder tracker.
package emt_pkg;

  localparam int unsigned POS_W   = 13;
  localparam int unsigned TH_W    = 13;
  localparam int unsigned CAL_W   = 8;
  localparam int unsigned TURN_W  = 24;
  localparam int unsigned RATE_W  = 14;
  localparam int unsigned TOTAL_W = 38;
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;

  // one full turn of the position field
  localparam int unsigned COUNTS_PER_TURN = 2 ** POS_W;

  localparam logic [TH_W-1:0]  THRESH_RST = 13'd4096;
  localparam logic [CAL_W-1:0] CAL_RST    = 8'd51;

  localparam logic signed [RATE_W-1:0] RATE_MAX = 14'sd8191;
  localparam logic signed [TURN_W-1:0] TURN_MAX = 24'sh7FFFFF;
  localparam logic signed [TURN_W-1:0] TURN_MIN = 24'sh800000;

  // Register index as decoded from paddr[2]
  typedef enum logic [0:0] {
    REG_WRAP_THRESHOLD = 1'b0,
    REG_CAL_MESSAGES   = 1'b1
  } cfg_reg_e;

  // Classification of one reading step
  typedef enum logic [1:0] {
    STEP_PLAIN   = 2'd0,
    STEP_WRAP_DN = 2'd1,
    STEP_WRAP_UP = 2'd2
  } step_kind_e;

  // One classified request between front and back
  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  offset;
    logic signed [POS_W:0] step;
    step_kind_e        kind;
    logic              cal;
  } req_t;

  typedef struct packed {
    logic       full;
    logic [1:0] count;
  } queue_stat_t;

  typedef struct packed {
    logic stage_valid;
    logic stall;
  } back_stat_t;

endpackage

[rtl/core/emt_if.sv]
// Valid/ready stream interfaces for encoder readings and tracker results.
interface emt_in_if;
  import emt_pkg::*;
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] encoder_position;
  modport source (output valid, output encoder_position, input ready);
  modport sink (input valid, input encoder_position, output ready);
endinterface

interface emt_out_if;
  import emt_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [TOTAL_W-1:0] total_count;
  logic signed [TURN_W-1:0]  turn_count;
  logic signed [RATE_W-1:0]  raw_rate;
  logic signed [RATE_W-1:0]  filtered_rate;
  logic                      calibrating;
  modport source (output valid, output total_count, output turn_count, output raw_rate,
                  output filtered_rate, output calibrating, input ready);
  modport sink (input valid, input total_count, input turn_count, input raw_rate,
                input filtered_rate, input calibrating, output ready);
endinterface

[rtl/core/emt_front.sv]
// Front end: accepts readings, tracks calibration and classifies each step.
module emt_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic [emt_pkg::POS_W-1:0] pos_i,
  input  logic [emt_pkg::TH_W-1:0]  thresh_i,
  input  logic [emt_pkg::CAL_W-1:0] cal_msgs_i,
  input  logic                    q_full_i,
  output logic                    ready_o,
  output logic                    push_o,
  output emt_pkg::req_t           req_o
);
  import emt_pkg::*;

  logic [CAL_W-1:0] cal_cnt_q, cal_cnt_d;
  logic [POS_W-1:0] prev_q, prev_d;
  logic [POS_W-1:0] off_q, off_d;
  logic             cal;
  logic signed [POS_W:0] step;
  logic signed [POS_W:0] th;
  step_kind_e       kind;

  assign ready_o = !q_full_i;
  assign push_o  = valid_i && !q_full_i;

  always_comb begin
    cal  = cal_cnt_q < cal_msgs_i;
    step = $signed({1'b0, pos_i}) - $signed({1'b0, prev_q});
    th   = $signed({1'b0, thresh_i});
    if (step > th) begin
      kind = STEP_WRAP_DN;
    end else if (step < -th) begin
      kind = STEP_WRAP_UP;
    end else begin
      kind = STEP_PLAIN;
    end

    cal_cnt_d = cal_cnt_q;
    prev_d    = prev_q;
    off_d     = off_q;
    if (push_o) begin
      prev_d = pos_i;
      if (cal) begin
        cal_cnt_d = cal_cnt_q + 1'b1;
        off_d     = pos_i;
      end
    end

    req_o.pos    = pos_i;
    req_o.offset = cal ? pos_i : off_q;
    req_o.step   = step;
    req_o.kind   = kind;
    req_o.cal    = cal;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_cnt_q <= '0;
      prev_q    <= '0;
      off_q     <= '0;
    end else begin
      cal_cnt_q <= cal_cnt_d;
      prev_q    <= prev_d;
      off_q     <= off_d;
    end
  end

endmodule

[rtl/core/emt_queue.sv]
// Two-entry request queue between front and back.
module emt_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  emt_pkg::req_t       req_i,
  input  logic                pop_i,
  output logic                valid_o,
  output emt_pkg::req_t       head_o,
  output emt_pkg::queue_stat_t stat_o
);
  import emt_pkg::*;

  req_t       slots_q [2];
  logic [1:0] count_q, count_d;
  logic       wptr_q, rptr_q;

  assign valid_o      = count_q != 2'd0;
  assign head_o       = slots_q[rptr_q];
  assign stat_o.full  = count_q == 2'd2;
  assign stat_o.count = count_q;

  always_comb begin
    count_d = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wptr_q] <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
    end
  end

endmodule

[rtl/core/emt_back.sv]
// Back end: turn counting, running-sum average, total count and result register.
module emt_back #(
  parameter int unsigned AVERAGE_DEPTH   = 25
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             q_valid_i,
  input  emt_pkg::req_t                    q_head_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [emt_pkg::TOTAL_W-1:0] total_o,
  output logic signed [emt_pkg::TURN_W-1:0]  turn_o,
  output logic signed [emt_pkg::RATE_W-1:0]  raw_o,
  output logic signed [emt_pkg::RATE_W-1:0]  filt_o,
  output logic                             cal_o,
  output emt_pkg::back_stat_t              stat_o
);
  import emt_pkg::*;

  localparam int unsigned CptBits = $clog2(COUNTS_PER_TURN);
  localparam int unsigned CPT_W   = (CptBits > POS_W) ? CptBits : POS_W;
  localparam int unsigned WIDE_W  = CPT_W + 2;
  localparam int unsigned SUM_W   = $clog2(AVERAGE_DEPTH * 8191 + 1) + 1;
  localparam int unsigned MAG_W   = SUM_W - 1;
  localparam int unsigned SLOT_W  = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
  localparam int unsigned SH      = MAG_W + $clog2(AVERAGE_DEPTH);
  localparam int unsigned RECIP_W = MAG_W + 1;
  localparam int unsigned PROD_W  = MAG_W + RECIP_W;
  localparam int unsigned Q_W     = RATE_W - 1;
  localparam int unsigned TOT_W   = TURN_W + CPT_W + 3;

  // ceil(2^SH / depth): exact floor division for every sum magnitude
  localparam logic [RECIP_W-1:0] Recip =
    RECIP_W'(((64'd1 << SH) + 64'(AVERAGE_DEPTH) - 64'd1) / 64'(AVERAGE_DEPTH));
  localparam logic signed [WIDE_W-1:0] CptWide = WIDE_W'(COUNTS_PER_TURN);
  localparam logic signed [TOT_W-1:0]  CptTot  = TOT_W'(COUNTS_PER_TURN);
  localparam logic signed [WIDE_W-1:0] RateHi  = WIDE_W'(8191);
  localparam logic signed [WIDE_W-1:0] RateLo  = -RateHi;
  localparam logic [SLOT_W-1:0]        LastSlot = SLOT_W'(AVERAGE_DEPTH - 1);

  // sample store and running state
  logic signed [RATE_W-1:0] samples_mem [AVERAGE_DEPTH];
  logic [AVERAGE_DEPTH-1:0] sample_vld_q;
  logic [SLOT_W-1:0]        slot_q, slot_d;
  logic signed [RATE_W-1:0] oldest_q;
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic signed [TURN_W-1:0] turns_q, turns_d;
  logic signed [RATE_W-1:0] held_q;

  // stage A
  logic                     adv, wr;
  logic signed [WIDE_W-1:0] step_w, raw_w;
  logic signed [RATE_W-1:0] raw_clamp, raw;

  // stage B
  logic                     b_valid_q;
  logic signed [TURN_W-1:0] b_turns_q;
  logic signed [SUM_W-1:0]  b_sum_q;
  logic [POS_W-1:0]         b_pos_q, b_off_q;
  logic signed [RATE_W-1:0] b_raw_q;
  logic                     b_cal_q;
  logic signed [TOT_W-1:0]  prod_tot, total_w;
  logic signed [POS_W:0]    pos_diff;
  logic [MAG_W-1:0]         mag;
  logic [PROD_W-1:0]        prod;
  logic [Q_W-1:0]           quot;
  logic signed [RATE_W-1:0] filt;

  // result register
  logic                      out_valid_q;
  logic signed [TOTAL_W-1:0] total_q;
  logic signed [TURN_W-1:0]  turn_q;
  logic signed [RATE_W-1:0]  raw_q, filt_q;
  logic                      cal_q;

  assign adv   = !out_valid_q || out_ready_i;
  assign pop_o = q_valid_i && adv;
  assign wr    = pop_o && !q_head_i.cal;

  assign stat_o.stage_valid = b_valid_q;
  assign stat_o.stall       = b_valid_q && !adv;

  always_comb begin
    step_w = WIDE_W'($signed(q_head_i.step));
    case (q_head_i.kind)
      STEP_WRAP_DN: raw_w = step_w - CptWide;
      STEP_WRAP_UP: raw_w = step_w + CptWide;
      default:      raw_w = step_w;
    endcase
    if (raw_w > RateHi) begin
      raw_clamp = RATE_MAX;
    end else if (raw_w < RateLo) begin
      raw_clamp = -RATE_MAX;
    end else begin
      raw_clamp = raw_w[RATE_W-1:0];
    end
    raw = q_head_i.cal ? '0 : raw_clamp;

    turns_d = turns_q;
    if (wr) begin
      case (q_head_i.kind)
        STEP_WRAP_DN: if (turns_q != TURN_MIN) turns_d = turns_q - 1'b1;
        STEP_WRAP_UP: if (turns_q != TURN_MAX) turns_d = turns_q + 1'b1;
        default:      turns_d = turns_q;
      endcase
    end

    sum_d = sum_q;
    if (wr) begin
      sum_d = sum_q + SUM_W'(raw) - SUM_W'(oldest_q);
    end

    slot_d = (slot_q == LastSlot) ? '0 : slot_q + 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      samples_mem[slot_q] <= raw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_vld_q <= '0;
      slot_q       <= '0;
      oldest_q     <= '0;
      sum_q        <= '0;
      turns_q      <= '0;
    end else begin
      sum_q   <= sum_d;
      turns_q <= turns_d;
      if (wr) begin
        sample_vld_q[slot_q] <= 1'b1;
        slot_q               <= slot_d;
        // prefetch the entry the next sample will replace
        if (slot_d == slot_q) begin
          oldest_q <= raw;
        end else if (sample_vld_q[slot_d]) begin
          oldest_q <= samples_mem[slot_d];
        end else begin
          oldest_q <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_turns_q <= turns_d;
      b_sum_q   <= sum_d;
      b_pos_q   <= q_head_i.pos;
      b_off_q   <= q_head_i.offset;
      b_raw_q   <= raw;
      b_cal_q   <= q_head_i.cal;
    end
  end

  always_comb begin
    prod_tot = TOT_W'(b_turns_q) * CptTot;
    pos_diff = $signed({1'b0, b_pos_q}) - $signed({1'b0, b_off_q});
    total_w  = prod_tot + TOT_W'(pos_diff);

    mag  = b_sum_q[SUM_W-1] ? MAG_W'(-b_sum_q) : MAG_W'(b_sum_q);
    prod = PROD_W'(mag) * PROD_W'(Recip);
    quot = Q_W'(prod >> SH);
    filt = b_sum_q[SUM_W-1] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      total_q <= total_w[TOTAL_W-1:0];
      turn_q  <= b_turns_q;
      raw_q   <= b_raw_q;
      filt_q  <= b_cal_q ? held_q : filt;
      cal_q   <= b_cal_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      held_q      <= '0;
    end else if (adv) begin
      b_valid_q   <= q_valid_i;
      out_valid_q <= b_valid_q;
      if (b_valid_q && !b_cal_q) begin
        held_q <= filt;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign total_o     = total_q;
  assign turn_o      = turn_q;
  assign raw_o       = raw_q;
  assign filt_o      = filt_q;
  assign cal_o       = cal_q;

endmodule

[rtl/core/encoder_multiturn_tracker.sv]
// Multiturn encoder tracker top level: APB registers, front, request queue, back.
// A reading passes the queue, stage B and the result register. Throughput: one reading
//   per cycle unless out_o stalls; the turn counter and the running sum update once per
//   request, and the moving-average divide is a reciprocal multiply in the last stage.
// Reset (rst_ni, async low): threshold 4096, calibration 51, all tracking state zero; the
//   sample valid flags clear at once, so there is no clearing pass.
module encoder_multiturn_tracker #(
  parameter int unsigned AVERAGE_DEPTH   = 25
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  emt_in_if.sink                        in_i,
  emt_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [emt_pkg::APB_AW-1:0]    paddr,
  input  logic [emt_pkg::APB_DW-1:0]    pwdata,
  output logic [emt_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);
  import emt_pkg::*;

  // Configuration registers
  logic [TH_W-1:0]  thresh_q;
  logic [CAL_W-1:0] cal_msgs_q;
  cfg_reg_e         reg_sel;
  logic             cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_sel)
      REG_WRAP_THRESHOLD: prdata = APB_DW'(thresh_q);
      REG_CAL_MESSAGES:   prdata = APB_DW'(cal_msgs_q);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q   <= THRESH_RST;
      cal_msgs_q <= CAL_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_WRAP_THRESHOLD: thresh_q   <= pwdata[TH_W-1:0];
        REG_CAL_MESSAGES:   cal_msgs_q <= pwdata[CAL_W-1:0];
        default:            thresh_q   <= thresh_q;
      endcase
    end
  end

  // Front: calibration tracking and step classification
  logic        push;
  req_t        push_req;
  queue_stat_t q_stat;

  emt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_i.valid),
    .pos_i      (in_i.encoder_position),
    .thresh_i   (thresh_q),
    .cal_msgs_i (cal_msgs_q),
    .q_full_i   (q_stat.full),
    .ready_o    (in_i.ready),
    .push_o     (push),
    .req_o      (push_req)
  );

  // Queue decouples intake from the back-end stall
  logic pop;
  logic q_valid;
  req_t q_head;

  emt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .req_i   (push_req),
    .pop_i   (pop),
    .valid_o (q_valid),
    .head_o  (q_head),
    .stat_o  (q_stat)
  );

  // Back: turns, moving average, total count, result register
  back_stat_t back_stat;

  emt_back #(
    .AVERAGE_DEPTH   (AVERAGE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .pop_o       (pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .total_o     (out_o.total_count),
    .turn_o      (out_o.turn_count),
    .raw_o       (out_o.raw_rate),
    .filt_o      (out_o.filtered_rate),
    .cal_o       (out_o.calibrating),
    .stat_o      (back_stat)
  );

`ifndef SYNTHESIS
  // calibration results never carry a rate step
  a_cal_raw_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.calibrating |-> out_o.raw_rate == '0)
    else $error("calibrating result with nonzero raw rate");

  // a stalled middle stage keeps its request
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.stall |=> back_stat.stage_valid)
    else $error("back stage request lost under stall");

  // queue fill moves by at most one entry per cycle
  a_queue_fill_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(q_stat.count) == 2'd0 |-> q_stat.count != 2'd2)
    else $error("queue fill jumped up by two");

  a_queue_fill_dn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(q_stat.count) == 2'd2 |-> q_stat.count != 2'd0)
    else $error("queue fill dropped by two");
`endif

endmodule

[tb/encoder_multiturn_tracker_tb.sv]
`timescale 1ns / 1ps
// Testbench for the multiturn encoder tracker: directed table plus random motion, self-checking.
module encoder_multiturn_tracker_tb;
  import emt_pkg::*;

  localparam int AVG_DEPTH   = 25;
  localparam int TURN_COUNTS = 8192;

  // One expected or observed tracker result, fields at port widths
  typedef struct packed {
    logic signed [TOTAL_W-1:0] total;
    logic signed [TURN_W-1:0]  turn;
    logic signed [RATE_W-1:0]  raw;
    logic signed [RATE_W-1:0]  filt;
    logic                      cal;
  } tracker_result_t;

  // Typed-in expectation travelling with a request; has = 0 means use the predictor
  typedef struct packed {
    logic            has;
    tracker_result_t res;
  } fixed_result_t;

  typedef enum logic {
    ROW_READING,
    ROW_CONFIG
  } row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    cfg_reg_e          sel;
    logic [APB_DW-1:0] value;
    logic              has_want;
    tracker_result_t   want;
  } stim_row_t;

  localparam int DIR_ROWS = 24;

  // Directed part. Starts from reset (threshold 4096, 51 calibration readings).
  stim_row_t dir_table [DIR_ROWS] = '{
    // first readings after reset only capture the offset: everything zero, flag set
    '{ROW_READING, REG_WRAP_THRESHOLD, 32'd0,    1'b1, '{38'sd0, 24'sd0, 14'sd0, 14'sd0, 1'b1}},
    '{ROW_READING, REG_WRAP_THRESHOLD, 32'd8191, 1'b1, '{38'sd0, 24'sd0, 14'sd0, 14'sd0, 1'b1}},
    // end calibration early: offset stays at 8191
    '{ROW_CONFIG,  REG_CAL_MESSAGES,   32'd0,    1'b0, '0},
    // full-scale step down wraps one turn up, then straight back
    '{ROW_READING, REG_WRAP_THRESHOLD, 32'd0,    1'b1, '{38'sd1, 24'sd1, 14'sd1, 14'sd0, 1'b0}},
    '{ROW_READING, REG_WRAP_THRESHOLD, 32'd8191, 1'b1, '{38'sd0, 24'sd0, -14'sd1, 14'sd0, 1'b0}},
    // steps of exactly +/-threshold stay plain, one count more wraps
    '{ROW_READING, REG_WRAP_THRESHOLD, 32'd4095, 1'b0, '0},
    '{ROW_READING, REG_WRAP_THRESHOLD, 32'd8191, 1'b0, '0},
    '{ROW_READING, REG_WRAP_THRESHOLD, 32'd4094, 1'b0, '0},
    '{ROW_READING, REG_WRAP_THRESHOLD, 32'd8191, 1'b0, '0},
    // threshold of one
    '{ROW_CONFIG,  REG_WRAP_THRESHOLD, 32'd1,    1'b0, '0},
    '{ROW_READING, REG_WRAP_THRESHOLD, 32'd8190, 1'b0, '0},
    '{ROW_READING, REG_WRAP_THRESHOLD, 32'd0,    1'b0, '0},
    '{ROW_READING, REG_WRAP_THRESHOLD, 32'd2,    1'b0, '0},
    '{ROW_READING, REG_WRAP_THRESHOLD, 32'd0,    1'b0, '0},
    // zero threshold: any nonzero step is a wrap
    '{ROW_CONFIG,  REG_WRAP_THRESHOLD, 32'd0,    1'b0, '0},
    '{ROW_READING, REG_WRAP_THRESHOLD, 32'd0,    1'b0, '0},
    '{ROW_READING, REG_WRAP_THRESHOLD, 32'd1,    1'b0, '0},
    '{ROW_READING, REG_WRAP_THRESHOLD, 32'd0,    1'b0, '0},
    // largest threshold: full-scale steps are plain
    '{ROW_CONFIG,  REG_WRAP_THRESHOLD, 32'd8191, 1'b0, '0},
    '{ROW_READING, REG_WRAP_THRESHOLD, 32'd8191, 1'b0, '0},
    '{ROW_READING, REG_WRAP_THRESHOLD, 32'd0,    1'b0, '0},
    '{ROW_READING, REG_WRAP_THRESHOLD, 32'd4096, 1'b0, '0},
    '{ROW_READING, REG_WRAP_THRESHOLD, 32'd5461, 1'b0, '0},
    '{ROW_READING, REG_WRAP_THRESHOLD, 32'd2730, 1'b0, '0}
  };

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  emt_in_if  in_if ();
  emt_out_if out_if ();

  encoder_multiturn_tracker i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Register shadows and tracking state of the predictor
  logic [TH_W-1:0]  wrap_thr     = THRESH_RST;
  logic [CAL_W-1:0] cal_limit    = CAL_RST;
  logic [POS_W-1:0] last_pos     = '0;
  logic [POS_W-1:0] offset_pos   = '0;
  int               turn_cnt     = 0;
  int               cal_seen     = 0;
  int               rate_hist [AVG_DEPTH] = '{default: 0};
  int               hist_slot    = 0;
  int               rate_total   = 0;
  int               avg_rate_held = 0;

  tracker_result_t pending_results [$];
  fixed_result_t   fixed_results [$];
  int              mismatches     = 0;
  int              readings_taken = 0;
  int              burst_left     = 0;

  function automatic int clamp_rate(input int rate);
    if (rate > int'(RATE_MAX)) return int'(RATE_MAX);
    if (rate < -int'(RATE_MAX)) return -int'(RATE_MAX);
    return rate;
  endfunction

  // Advances the tracking state by one reading and returns the result it should produce.
  function automatic tracker_result_t track_reading(input logic [POS_W-1:0] pos);
    tracker_result_t res;
    int              step;
    int              rate;
    longint          total;
    rate    = 0;
    res.cal = 1'b0;
    if (cal_seen < int'(cal_limit)) begin
      // offset capture only; the counter stops at the register value and never wraps
      res.cal    = 1'b1;
      cal_seen++;
      last_pos   = pos;
      offset_pos = pos;
    end else begin
      step = int'(pos) - int'(last_pos);
      if (step > int'(wrap_thr)) begin
        if (turn_cnt > int'(TURN_MIN)) turn_cnt--;
        rate = step - TURN_COUNTS;
      end else if (step < -int'(wrap_thr)) begin
        if (turn_cnt < int'(TURN_MAX)) turn_cnt++;
        rate = step + TURN_COUNTS;
      end else begin
        rate = step;
      end
      rate     = clamp_rate(rate);
      last_pos = pos;
      // running sum over the last AVG_DEPTH rates
      rate_total += rate - rate_hist[hist_slot];
      rate_hist[hist_slot] = rate;
      hist_slot     = (hist_slot + 1) % AVG_DEPTH;
      avg_rate_held = clamp_rate(rate_total / AVG_DEPTH);
    end
    total = longint'(turn_cnt) * TURN_COUNTS + longint'(pos) - longint'(offset_pos);
    res.total = total[TOTAL_W-1:0];
    res.turn  = turn_cnt[TURN_W-1:0];
    res.raw   = rate[RATE_W-1:0];
    res.filt  = avg_rate_held[RATE_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) $display("%0t: mismatch: %s", $time, what);
  endtask

  // Drops valid and waits until every request has produced its result, plus the pipe depth.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // APB write followed by a read-back; the shadow register follows at the write edge.
  task automatic write_register(input cfg_reg_e sel, input logic [APB_DW-1:0] value);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (sel == REG_WRAP_THRESHOLD) wrap_thr = value[TH_W-1:0];
    else cal_limit = value[CAL_W-1:0];
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== value)
      report_mismatch($sformatf("%s read back %0d, want %0d", sel.name(), prdata, value));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Offers one reading, waits for the request to be taken, then may idle a random gap.
  task automatic send_reading(input logic [POS_W-1:0] pos, input logic has_want,
                              input tracker_result_t want);
    int gap;
    int roll;
    fixed_results.push_back('{has_want, want});
    in_if.encoder_position <= pos;
    in_if.valid            <= 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 3) burst_left = $urandom_range(20, 80);
      else if (roll < 25) gap = $urandom_range(1, 3);
      else if (roll < 31) gap = $urandom_range(4, 10);
      else if (roll < 33) gap = $urandom_range(20, 40);
    end
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case a result never shows up or the input never frees.
  initial begin
    #5_000_000;
    $display("encoder_multiturn_tracker_tb: FAIL");
    $finish;
  end

  // Result side: free-running, choppy and stalled stretches, plus one long hold-off
  // while readings are still offered so the internal queue fills and input stalls.
  initial begin : result_sink
    typedef enum logic [1:0] {
      SINK_FREE,
      SINK_CHOPPY,
      SINK_STALL
    } sink_mode_e;
    sink_mode_e mode;
    int         stretch_left;
    int         roll;
    bit         pressure_done;
    mode          = SINK_FREE;
    stretch_left  = 0;
    pressure_done = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (!pressure_done && readings_taken >= 300 && in_if.valid) begin
        pressure_done = 1'b1;
        out_if.ready <= 1'b0;
        repeat (150) @(negedge clk_i);
      end else begin
        if (stretch_left == 0) begin
          roll = $urandom_range(0, 99);
          if (roll < 40) begin
            mode         = SINK_FREE;
            stretch_left = $urandom_range(8, 60);
          end else if (roll < 90) begin
            mode         = SINK_CHOPPY;
            stretch_left = $urandom_range(8, 40);
          end else begin
            mode         = SINK_STALL;
            stretch_left = $urandom_range(4, 30);
          end
        end
        stretch_left--;
        case (mode)
          SINK_FREE:   out_if.ready <= 1'b1;
          SINK_CHOPPY: out_if.ready <= ($urandom_range(0, 2) != 0);
          default:     out_if.ready <= 1'b0;
        endcase
      end
    end
  end

  // Checker: results compared against the oldest expectation first, then new requests
  // are run through the predictor. Results trail requests through the request queue,
  // stage B and the result register, so the order within one edge never matters.
  always @(posedge clk_i) begin : observe
    tracker_result_t got;
    tracker_result_t want;
    fixed_result_t   fixed;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.total_count, out_if.turn_count, out_if.raw_rate,
                out_if.filtered_rate, out_if.calibrating};
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending");
        end else begin
          want = pending_results.pop_front();
          if (got.total !== want.total)
            report_mismatch($sformatf("total_count %0d, want %0d", got.total, want.total));
          if (got.turn !== want.turn)
            report_mismatch($sformatf("turn_count %0d, want %0d", got.turn, want.turn));
          if (got.raw !== want.raw)
            report_mismatch($sformatf("raw_rate %0d, want %0d", got.raw, want.raw));
          if (got.filt !== want.filt)
            report_mismatch($sformatf("filtered_rate %0d, want %0d", got.filt, want.filt));
          if (got.cal !== want.cal)
            report_mismatch($sformatf("calibrating %0b, want %0b", got.cal, want.cal));
        end
      end
      if (in_if.valid && in_if.ready) begin
        readings_taken++;
        want  = track_reading(in_if.encoder_position);
        fixed = fixed_results.pop_front();
        pending_results.push_back(fixed.has ? fixed.res : want);
      end
    end
  end

  // Stimulus: directed table, then random motion under several register settings.
  initial begin : stimulus
    int unsigned      phase_thr [6] = '{4096, 8191, 1, 0, 0, 4096};
    int unsigned      phase_cal [6] = '{51, 255, 0, 128, 0, 51};
    int               phase_len [6] = '{160, 320, 140, 140, 140, 140};
    int unsigned      thr;
    int unsigned      cal;
    logic [POS_W-1:0] cur_pos;
    int               speed;
    int               delta;
    int               roll;
    psel                   <= 1'b0;
    penable                <= 1'b0;
    pwrite                 <= 1'b0;
    paddr                  <= '0;
    pwdata                 <= '0;
    in_if.valid            <= 1'b0;
    in_if.encoder_position <= '0;
    rst_ni                 <= 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_CONFIG)
        write_register(dir_table[i].sel, dir_table[i].value);
      else
        send_reading(dir_table[i].value[POS_W-1:0], dir_table[i].has_want, dir_table[i].want);
    end

    // Calibration counter is at 2 here: the first two phases resume offset capture,
    // the second one up to the 255 ceiling, after which it never comes back.
    cur_pos = dir_table[DIR_ROWS-1].value[POS_W-1:0];
    speed   = 0;
    for (int ph = 0; ph < 6; ph++) begin
      thr = phase_thr[ph];
      cal = phase_cal[ph];
      if (ph == 4) begin
        thr = $urandom_range(1, 8191);
        cal = $urandom_range(0, 255);
      end
      write_register(REG_WRAP_THRESHOLD, thr);
      write_register(REG_CAL_MESSAGES, cal);
      for (int n = 0; n < phase_len[ph]; n++) begin
        if (wrap_thr == '0 && n < 60) begin
          // slow creep with zero threshold: every step wraps, average runs to full scale
          delta = (n < 30) ? -1 : 1;
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 6) speed = int'($urandom_range(0, 12000)) - 6000;
          else if (roll < 10) speed = int'($urandom_range(0, 400)) - 200;
          if (roll >= 10 && roll < 14)
            delta = int'($urandom_range(0, 8191));
          else if (roll >= 14 && roll < 17)
            // land right around the wrap threshold in either direction
            delta = (($urandom_range(0, 1) != 0) ? 1 : -1) *
                    (int'(wrap_thr) + int'($urandom_range(0, 2)) - 1);
          else
            delta = speed + int'($urandom_range(0, 6)) - 3;
        end
        cur_pos = cur_pos + POS_W'(delta);
        send_reading(cur_pos, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) $display("encoder_multiturn_tracker_tb: PASS");
    else $display("encoder_multiturn_tracker_tb: FAIL");
    $finish;
  end

endmodule

[encoder_multiturn_tracker.f]
rtl/core/emt_pkg.sv
rtl/core/emt_if.sv
rtl/core/emt_front.sv
rtl/core/emt_queue.sv
rtl/core/emt_back.sv
rtl/core/encoder_multiturn_tracker.sv
tb/encoder_multiturn_tracker_tb.sv
